// ===== hw/rtl/point_rotate_scale_about_center_top_macros.svh =====
// assertion macros for the point rotate and scale block
`ifndef POINT_ROTATE_SCALE_ABOUT_CENTER_TOP_MACROS_SVH
`define POINT_ROTATE_SCALE_ABOUT_CENTER_TOP_MACROS_SVH

// clocked assertion, held off during reset
`define PRSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define PRSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/prsc_pkg.sv =====
// shared types, constants and the arctangent table of the point rotate and scale block
package prsc_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int PHASE_W = 32;
	localparam int THR_W = 31;
	localparam int DW = COORD_W + 1;
	localparam int CW = 34;
	localparam int PW = DW + CW + 1;
	localparam int SW = PW + 2;
	localparam int STEPS = 28;
	localparam int STEPS_PER_STAGE = 4;
	localparam int CORDIC_STAGES = STEPS / STEPS_PER_STAGE;
	localparam int NST = CORDIC_STAGES + 5;
	localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
	localparam logic ACT_ROTATE = 1'b0;
	localparam logic ACT_SCALE = 1'b1;

	// item fields carried alongside the cordic
	typedef struct packed {
		logic action;
		logic flip;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [COORD_W-1:0] pvx;
		logic signed [COORD_W-1:0] pvy;
		logic signed [COORD_W-1:0] ratio;
	} pay_t;

	// cordic vector and residual phase
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [PHASE_W-1:0] z;
	} cor_t;

	// products and what the back end needs
	typedef struct packed {
		logic action;
		logic flip;
		logic signed [COORD_W-1:0] pvx;
		logic signed [COORD_W-1:0] pvy;
		logic signed [PW-1:0] m1;
		logic signed [PW-1:0] m2;
		logic signed [PW-1:0] m3;
		logic signed [PW-1:0] m4;
	} mul_t;

	// arctangent per cordic step in 32-bit phase units
	function automatic logic [PHASE_W-1:0] atan_at(input logic [4:0] i);
		logic [PHASE_W-1:0] a;
		case (i)
			5'd0: a = 32'h20000000;
			5'd1: a = 32'h12E4051E;
			5'd2: a = 32'h09FB385B;
			5'd3: a = 32'h051111D4;
			5'd4: a = 32'h028B0D43;
			5'd5: a = 32'h0145D7E1;
			5'd6: a = 32'h00A2F61E;
			5'd7: a = 32'h00517C55;
			5'd8: a = 32'h0028BE53;
			5'd9: a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/prsc_front.sv =====
// input stage: offsets from the pivot and cordic start vector
module prsc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  logic action,
	input  logic signed [prsc_pkg::COORD_W-1:0] point_x,
	input  logic signed [prsc_pkg::COORD_W-1:0] point_y,
	input  logic signed [prsc_pkg::COORD_W-1:0] pivot_x,
	input  logic signed [prsc_pkg::COORD_W-1:0] pivot_y,
	input  logic [prsc_pkg::ANGLE_W-1:0] turn_angle,
	input  logic signed [prsc_pkg::COORD_W-1:0] ratio,
	output logic vld_o,
	output prsc_pkg::pay_t pay_o,
	output prsc_pkg::cor_t cor_o
);

	logic [prsc_pkg::PHASE_W-1:0] z0;
	logic flip;
	prsc_pkg::pay_t pay_d;
	prsc_pkg::cor_t cor_d;

	// widen angle to phase, fold second and third quadrants
	always_comb begin
		z0 = {turn_angle, {(prsc_pkg::PHASE_W-prsc_pkg::ANGLE_W){1'b0}}};
		flip = z0[prsc_pkg::PHASE_W-1] ^ z0[prsc_pkg::PHASE_W-2];
		pay_d.action = action;
		pay_d.flip = flip;
		pay_d.dx = prsc_pkg::DW'(point_x) - prsc_pkg::DW'(pivot_x);
		pay_d.dy = prsc_pkg::DW'(point_y) - prsc_pkg::DW'(pivot_y);
		pay_d.pvx = pivot_x;
		pay_d.pvy = pivot_y;
		pay_d.ratio = ratio;
		cor_d.x = prsc_pkg::CORDIC_GAIN;
		cor_d.y = '0;
		cor_d.z = {z0[prsc_pkg::PHASE_W-1] ^ flip, z0[prsc_pkg::PHASE_W-2:0]};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			pay_o <= pay_d;
			cor_o <= cor_d;
		end
	end

endmodule

// ===== hw/rtl/prsc_cordic_stage.sv =====
// one pipeline stage of the rotation-mode cordic, a few steps each
module prsc_cordic_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] step_base,
	input  logic vld_i,
	input  prsc_pkg::pay_t pay_i,
	input  prsc_pkg::cor_t cor_i,
	output logic vld_o,
	output prsc_pkg::pay_t pay_o,
	output prsc_pkg::cor_t cor_o
);

	prsc_pkg::cor_t c;
	logic signed [prsc_pkg::CW-1:0] xs;
	logic signed [prsc_pkg::CW-1:0] ys;
	logic [4:0] k;

	// micro-rotations, direction from phase sign
	always_comb begin
		c = cor_i;
		xs = '0;
		ys = '0;
		k = '0;
		for (int j = 0; j < prsc_pkg::STEPS_PER_STAGE; j++) begin
			k = step_base + 5'(j);
			xs = c.x >>> k;
			ys = c.y >>> k;
			if (!c.z[prsc_pkg::PHASE_W-1]) begin
				c.x = c.x - ys;
				c.y = c.y + xs;
				c.z = c.z - prsc_pkg::atan_at(k);
			end else begin
				c.x = c.x + ys;
				c.y = c.y - xs;
				c.z = c.z + prsc_pkg::atan_at(k);
			end
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			pay_o <= pay_i;
			cor_o <= c;
		end
	end

endmodule

// ===== hw/rtl/prsc_mul.sv =====
// multiplier stage: offset times cosine and sine, or times the ratio
module prsc_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  prsc_pkg::pay_t pay_i,
	input  prsc_pkg::cor_t cor_i,
	output logic vld_o,
	output prsc_pkg::mul_t mul_o
);

	logic signed [prsc_pkg::CW-1:0] cf;
	logic signed [prsc_pkg::CW-1:0] sf;
	prsc_pkg::mul_t mul_d;

	// scale mode reuses the cosine path with the ratio and a zero sine
	always_comb begin
		if (pay_i.action == prsc_pkg::ACT_SCALE) begin
			cf = prsc_pkg::CW'(pay_i.ratio);
			sf = '0;
		end else begin
			cf = cor_i.x;
			sf = cor_i.y;
		end
		mul_d.action = pay_i.action;
		mul_d.flip = pay_i.flip && (pay_i.action == prsc_pkg::ACT_ROTATE);
		mul_d.pvx = pay_i.pvx;
		mul_d.pvy = pay_i.pvy;
		mul_d.m1 = prsc_pkg::PW'(pay_i.dx) * prsc_pkg::PW'(cf);
		mul_d.m2 = prsc_pkg::PW'(pay_i.dy) * prsc_pkg::PW'(sf);
		mul_d.m3 = prsc_pkg::PW'(pay_i.dy) * prsc_pkg::PW'(cf);
		mul_d.m4 = prsc_pkg::PW'(pay_i.dx) * prsc_pkg::PW'(sf);
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			mul_o <= mul_d;
		end
	end

endmodule

// ===== hw/rtl/prsc_post.sv =====
// back end: sum and round, add pivot, clamp and snap
module prsc_post (
	input  logic clk,
	input  logic arst_n,
	input  logic [2:0] en,
	input  logic vld_i,
	input  prsc_pkg::mul_t mul_i,
	input  logic [prsc_pkg::THR_W-1:0] thr,
	output logic [2:0] vld_o,
	output logic act_o,
	output logic signed [prsc_pkg::COORD_W-1:0] result_x,
	output logic signed [prsc_pkg::COORD_W-1:0] result_y,
	output logic saturated
);

	localparam int SH_ROT = 30;
	localparam int SH_SCL = 16;
	localparam logic signed [prsc_pkg::SW-1:0] CMAX = prsc_pkg::SW'((64'sd1 <<< (prsc_pkg::COORD_W-1)) - 64'sd1);
	localparam logic signed [prsc_pkg::SW-1:0] CMIN = -(CMAX + prsc_pkg::SW'(1));

	logic signed [prsc_pkg::SW-1:0] rnd;
	logic signed [prsc_pkg::SW-1:0] sx_d, sy_d;
	logic signed [prsc_pkg::SW-1:0] sx_s10, sy_s10;
	logic act_s10;
	logic signed [prsc_pkg::COORD_W-1:0] pvx_s10, pvy_s10;
	logic signed [prsc_pkg::SW-1:0] ax_d, ay_d;
	logic signed [prsc_pkg::SW-1:0] ax_s11, ay_s11;
	logic act_s11;
	logic signed [prsc_pkg::COORD_W-1:0] cx, cy;
	logic satx, saty;
	logic [prsc_pkg::COORD_W:0] magx, magy;
	logic snap_x, snap_y;

	// products combined with rounding bias
	always_comb begin
		rnd = (mul_i.action == prsc_pkg::ACT_SCALE) ? prsc_pkg::SW'(1 << (SH_SCL-1))
			: prsc_pkg::SW'(1 << (SH_ROT-1));
		if (mul_i.flip) begin
			sx_d = prsc_pkg::SW'(mul_i.m2) - prsc_pkg::SW'(mul_i.m1) + rnd;
			sy_d = rnd - prsc_pkg::SW'(mul_i.m3) - prsc_pkg::SW'(mul_i.m4);
		end else begin
			sx_d = prsc_pkg::SW'(mul_i.m1) - prsc_pkg::SW'(mul_i.m2) + rnd;
			sy_d = prsc_pkg::SW'(mul_i.m3) + prsc_pkg::SW'(mul_i.m4) + rnd;
		end
	end

	// scale back and add the pivot
	always_comb begin
		if (act_s10 == prsc_pkg::ACT_SCALE) begin
			ax_d = (sx_s10 >>> SH_SCL) + prsc_pkg::SW'(pvx_s10);
			ay_d = (sy_s10 >>> SH_SCL) + prsc_pkg::SW'(pvy_s10);
		end else begin
			ax_d = (sx_s10 >>> SH_ROT) + prsc_pkg::SW'(pvx_s10);
			ay_d = (sy_s10 >>> SH_ROT) + prsc_pkg::SW'(pvy_s10);
		end
	end

	// clamp to coordinate range, then snap small rotated values
	always_comb begin
		satx = 1'b1;
		saty = 1'b1;
		if (ax_s11 > CMAX) cx = prsc_pkg::COORD_W'(CMAX);
		else if (ax_s11 < CMIN) cx = prsc_pkg::COORD_W'(CMIN);
		else begin
			cx = prsc_pkg::COORD_W'(ax_s11);
			satx = 1'b0;
		end
		if (ay_s11 > CMAX) cy = prsc_pkg::COORD_W'(CMAX);
		else if (ay_s11 < CMIN) cy = prsc_pkg::COORD_W'(CMIN);
		else begin
			cy = prsc_pkg::COORD_W'(ay_s11);
			saty = 1'b0;
		end
		magx = cx[prsc_pkg::COORD_W-1] ? -(prsc_pkg::COORD_W+1)'(cx) : (prsc_pkg::COORD_W+1)'(cx);
		magy = cy[prsc_pkg::COORD_W-1] ? -(prsc_pkg::COORD_W+1)'(cy) : (prsc_pkg::COORD_W+1)'(cy);
		snap_x = (act_s11 == prsc_pkg::ACT_ROTATE) && (magx < (prsc_pkg::COORD_W+1)'(thr));
		snap_y = (act_s11 == prsc_pkg::ACT_ROTATE) && (magy < (prsc_pkg::COORD_W+1)'(thr));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= '0;
		end else begin
			if (en[0]) vld_o[0] <= vld_i;
			if (en[1]) vld_o[1] <= vld_o[0];
			if (en[2]) vld_o[2] <= vld_o[1];
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sx_s10 <= sx_d;
			sy_s10 <= sy_d;
			act_s10 <= mul_i.action;
			pvx_s10 <= mul_i.pvx;
			pvy_s10 <= mul_i.pvy;
		end
		if (en[1]) begin
			ax_s11 <= ax_d;
			ay_s11 <= ay_d;
			act_s11 <= act_s10;
		end
		if (en[2]) begin
			result_x <= snap_x ? '0 : cx;
			result_y <= snap_y ? '0 : cy;
			saturated <= satx | saty;
			act_o <= act_s11;
		end
	end

endmodule

// ===== hw/rtl/point_rotate_scale_about_center_top.sv =====
// top level of the point rotate and scale about pivot block
// Rotates a Q15.16 point about a pivot by a 16-bit binary angle, or scales
// its offset from the pivot by a Q15.16 ratio, with saturation flagged.
// Input channel: in_valid / in_stall with action, point, pivot, angle, ratio.
// Output channel: out_valid / out_stall with result_x, result_y, saturated.
// Config channel: cfg_valid / cfg_ready with cfg_data, the snap threshold;
// cfg_ready is always high, write only while no item is in flight.
// Registered path from input to result: one input stage, seven cordic stages
// of four steps, one multiply stage and three stages of sum, pivot add and
// clamp/snap. Throughput is one item per cycle with no stall.
// Each stage holds its item while the next is full and blocked; empty
// stages still fill, so the input keeps being taken until all 12 stages
// hold items, then in_stall rises until out_stall drops.
// Reset clears all valid bits and sets the snap threshold to one lsb.
module point_rotate_scale_about_center_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic action,
	input  logic signed [prsc_pkg::COORD_W-1:0] point_x,
	input  logic signed [prsc_pkg::COORD_W-1:0] point_y,
	input  logic signed [prsc_pkg::COORD_W-1:0] pivot_x,
	input  logic signed [prsc_pkg::COORD_W-1:0] pivot_y,
	input  logic [prsc_pkg::ANGLE_W-1:0] turn_angle,
	input  logic signed [prsc_pkg::COORD_W-1:0] ratio,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [prsc_pkg::COORD_W-1:0] result_x,
	output logic signed [prsc_pkg::COORD_W-1:0] result_y,
	output logic saturated,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [prsc_pkg::THR_W-1:0] cfg_data
);

	`include "point_rotate_scale_about_center_top_macros.svh"

	localparam int NC = prsc_pkg::CORDIC_STAGES;

	logic [prsc_pkg::THR_W-1:0] thr_q;
	logic [prsc_pkg::NST-1:0] vld;
	logic [prsc_pkg::NST-1:0] en;
	prsc_pkg::pay_t pay [NC+1];
	prsc_pkg::cor_t cor [NC+1];
	prsc_pkg::mul_t mul_w;
	logic act_last;
	logic [2:0] vld_post;

	// snap threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= prsc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// stage advances when empty or when the next one advances
	always_comb begin
		en[prsc_pkg::NST-1] = !vld[prsc_pkg::NST-1] || !out_stall;
		for (int k = prsc_pkg::NST-2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end
	assign in_stall = !en[0];

	prsc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en[0]), .vld_i(in_valid),
		.action(action), .point_x(point_x), .point_y(point_y),
		.pivot_x(pivot_x), .pivot_y(pivot_y), .turn_angle(turn_angle),
		.ratio(ratio), .vld_o(vld[0]), .pay_o(pay[0]), .cor_o(cor[0])
	);

	// cordic pipeline
	for (genvar g = 0; g < NC; g++) begin : g_cordic
		prsc_cordic_stage u_stage (
			.clk(clk), .arst_n(arst_n), .en(en[g+1]),
			.step_base(5'(g * prsc_pkg::STEPS_PER_STAGE)),
			.vld_i(vld[g]), .pay_i(pay[g]), .cor_i(cor[g]),
			.vld_o(vld[g+1]), .pay_o(pay[g+1]), .cor_o(cor[g+1])
		);
	end

	prsc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .en(en[NC+1]), .vld_i(vld[NC]),
		.pay_i(pay[NC]), .cor_i(cor[NC]), .vld_o(vld[NC+1]), .mul_o(mul_w)
	);

	prsc_post u_post (
		.clk(clk), .arst_n(arst_n), .en(en[NC+4:NC+2]), .vld_i(vld[NC+1]),
		.mul_i(mul_w), .thr(thr_q), .vld_o(vld_post), .act_o(act_last),
		.result_x(result_x), .result_y(result_y), .saturated(saturated)
	);
	assign vld[NC+4:NC+2] = vld_post;
	assign out_valid = vld[prsc_pkg::NST-1];

	// checks
	`PRSC_ASSERT(a_stall_full, in_stall |-> (&vld), "input stalled with an empty stage")
	`PRSC_ASSERT(a_drain, (out_valid && !out_stall && !vld[prsc_pkg::NST-2]) |=> !out_valid, "result repeated after transfer")
	`PRSC_ASSERT(a_scale_sat, (out_valid && saturated && (act_last == prsc_pkg::ACT_SCALE)) |-> ((result_x == {1'b0, {(prsc_pkg::COORD_W-1){1'b1}}}) || (result_x == {1'b1, {(prsc_pkg::COORD_W-1){1'b0}}}) || (result_y == {1'b0, {(prsc_pkg::COORD_W-1){1'b1}}}) || (result_y == {1'b1, {(prsc_pkg::COORD_W-1){1'b0}}})), "scale saturation without clamped value")
	`PRSC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

endmodule
